### rtl/rar_pkg.sv
// Package for the rational arithmetic reducer: widths, operation codes and
// the control bundle between sequencer and divider. No dependencies.
package rar_pkg;
  localparam int unsigned Width = 16;
  localparam int unsigned OutW  = 2 * Width + 1;
  localparam int unsigned WideW = 2 * Width + 2;
  localparam int unsigned CntW  = $clog2(WideW + 1);

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef struct packed {
    logic                    start;
    logic signed [WideW-1:0] dividend;
    logic signed [WideW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [WideW-1:0] quot;
    logic signed [WideW-1:0] rem;
  } div_rsp_t;
endpackage

### rtl/rar_if.sv
// Valid/ready channel interfaces for the rational arithmetic reducer.
// Depends on rar_pkg.
interface rar_in_if import rar_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic signed [Width-1:0] num_a;
  logic signed [Width-1:0] den_a;
  logic signed [Width-1:0] num_b;
  logic signed [Width-1:0] den_b;
  modport source (output valid, kind, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, kind, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rar_out_if import rar_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] result_num;
  logic signed [OutW-1:0] result_den;
  logic                   div_error;
  modport source (output valid, result_num, result_den, div_error, input ready);
  modport sink   (input valid, result_num, result_den, div_error, output ready);
endinterface

### rtl/rar_div.sv
// Shared bit-serial signed divider with truncated quotient and remainder.
// Depends on rar_pkg.
module rar_div import rar_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [WideW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic             nq_q, nr_q, busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [WideW:0]   trial;
  logic [WideW-1:0] shifted;
  logic [WideW-1:0] adiv, adsr;

  assign adiv = req_i.dividend[WideW-1] ? WideW'(-req_i.dividend) : req_i.dividend;
  assign adsr = req_i.divisor[WideW-1] ? WideW'(-req_i.divisor) : req_i.divisor;
  assign shifted = {rem_q[WideW-2:0], quo_q[WideW-1]};
  assign trial = {1'b0, shifted} - {1'b0, dvs_q};

  always_comb begin
    rem_d = shifted;
    quo_d = {quo_q[WideW-2:0], 1'b0};
    if (!trial[WideW] || rem_q[WideW-1]) begin
      rem_d = trial[WideW-1:0];
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rsp_o.done <= 1'b0;
    end else begin
      rsp_o.done <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WideW);
        rem_q  <= '0;
        quo_q  <= adiv;
        dvs_q  <= adsr;
        nq_q   <= req_i.dividend[WideW-1] ^ req_i.divisor[WideW-1];
        nr_q   <= req_i.dividend[WideW-1];
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q     <= 1'b0;
          rsp_o.done <= 1'b1;
          rsp_o.quot <= nq_q ? -$signed(quo_d) : $signed(quo_d);
          rsp_o.rem  <= nr_q ? -$signed(rem_d) : $signed(rem_d);
        end
      end
    end
  end
endmodule

### rtl/rational_arith_reduce.sv
// Top level of the rational arithmetic reducer: sequencer, multiplier stage
// and the shared divider. Depends on rar_pkg, rar_if and rar_div.
//
// Combines two signed fractions with add, subtract, multiply or divide and
// reduces the result by Euclid's gcd with truncated remainder; the gcd may
// be negative, so signs follow it. A zero denominator in add or subtract,
// or a zero-over-zero result, gives div_error with zero fields. One item at
// a time: the block is not ready until its result is taken. The item is
// accepted, its products are formed and the fraction is built, then the
// single bit-serial restoring divider runs once per Euclid remainder and
// twice more for the reduced numerator and denominator; each run is a
// start, one iteration per operand bit and a registered result. An error
// result never uses the divider.
module rational_arith_reduce import rar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rar_in_if.sink    in_i,
  rar_out_if.source out_o
);
  typedef enum logic [3:0] {
    StIdle, StMul1, StMul2, StForm, StGcdGo, StGcdWait, StQnGo, StQnWait,
    StQdGo, StQdWait, StOut
  } state_e;

  state_e                  state_q;
  logic [1:0]              kind_q;
  logic signed [Width-1:0] a_q, b_q, c_q, d_q;
  logic signed [WideW-1:0] p_q, q_q, num_q, den_q, m_q, n_q;
  logic signed [WideW-1:0] prod;
  logic signed [Width-1:0] mx, my;
  div_req_t                req;
  div_rsp_t                rsp;

  // One shared multiplier, used twice per item.
  always_comb begin
    unique case (state_q)
      StMul1:  begin
        mx = a_q;
        my = (kind_q == OpMul) ? c_q : d_q;
      end
      default: begin
        mx = (kind_q == OpMul || kind_q == OpDiv) ? b_q : c_q;
        my = (kind_q == OpMul) ? d_q : (kind_q == OpDiv ? c_q : b_q);
      end
    endcase
  end
  assign prod = WideW'(mx * my);

  always_comb begin
    req.start    = 1'b0;
    req.dividend = m_q;
    req.divisor  = n_q;
    unique case (state_q)
      StGcdGo: req.start = 1'b1;
      StQnGo:  begin
        req.start = 1'b1;
        req.dividend = num_q;
        req.divisor = m_q;
      end
      StQdGo:  begin
        req.start = 1'b1;
        req.dividend = den_q;
        req.divisor = m_q;
      end
      default: ;
    endcase
  end

  rar_div u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (in_i.valid) begin
          kind_q <= in_i.kind;
          a_q <= in_i.num_a; b_q <= in_i.den_a;
          c_q <= in_i.num_b; d_q <= in_i.den_b;
          state_q <= StMul1;
        end
        StMul1: begin
          p_q <= prod;
          state_q <= StMul2;
        end
        StMul2: begin
          q_q <= prod;
          state_q <= StForm;
        end
        StForm: begin
          // Add/subtract take the denominator from a further product.
          if (kind_q == OpAdd || kind_q == OpSub) begin
            if (b_q == '0 || d_q == '0) begin
              out_o.result_num <= '0;
              out_o.result_den <= '0;
              out_o.div_error  <= 1'b1;
              state_q <= StOut;
            end else begin
              num_q <= (kind_q == OpAdd) ? p_q + q_q : p_q - q_q;
              m_q   <= (kind_q == OpAdd) ? p_q + q_q : p_q - q_q;
              den_q <= WideW'(b_q * d_q);
              n_q   <= WideW'(b_q * d_q);
              state_q <= StGcdGo;
            end
          end else begin
            num_q <= p_q; m_q <= p_q;
            den_q <= q_q; n_q <= q_q;
            state_q <= StGcdGo;
          end
        end
        StGcdGo: begin
          if (n_q == '0) begin
            if (m_q == '0) begin
              out_o.result_num <= '0;
              out_o.result_den <= '0;
              out_o.div_error  <= 1'b1;
              state_q <= StOut;
            end else begin
              state_q <= StQnGo;
            end
          end else begin
            state_q <= StGcdWait;
          end
        end
        StGcdWait: if (rsp.done) begin
          m_q <= n_q;
          n_q <= rsp.rem;
          state_q <= StGcdGo;
        end
        StQnGo: state_q <= StQnWait;
        StQnWait: if (rsp.done) begin
          out_o.result_num <= OutW'(rsp.quot);
          state_q <= StQdGo;
        end
        StQdGo: state_q <= StQdWait;
        StQdWait: if (rsp.done) begin
          out_o.result_den <= OutW'(rsp.quot);
          out_o.div_error  <= 1'b0;
          state_q <= StOut;
        end
        StOut: if (out_o.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // An error result always carries zero fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.div_error |-> out_o.result_num == '0 && out_o.result_den == '0)
    else $error("error result with nonzero fields");
  // Never ready while a result is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("ready during output");
  // A result held and not taken stays valid with its numerator unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.result_num))
    else $error("result changed while stalled");
endmodule

### verif/tb_top.sv
// Self-checking testbench for rational_arith_reduce: random and directed
// fraction operations, checked against an in-bench gcd-reduction predictor.
// Depends on rar_pkg, rar_if and the RTL of rational_arith_reduce.
`timescale 1ns / 100ps

module tb_top;
  import rar_pkg::*;

  localparam int unsigned CycleLimit = 40_000_000;
  localparam int unsigned LongHold   = 3000;

  typedef struct packed {
    op_e                     kind;
    logic signed [Width-1:0] num_a;
    logic signed [Width-1:0] den_a;
    logic signed [Width-1:0] num_b;
    logic signed [Width-1:0] den_b;
  } frac_op_t;

  typedef struct packed {
    logic [OutW-1:0] num;
    logic [OutW-1:0] den;
    logic            err;
  } reduced_t;

  logic clk_i;
  logic rst_ni;

  rar_in_if  in_if ();
  rar_out_if out_if ();

  rational_arith_reduce DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  frac_op_t    pending_ops[$];
  reduced_t    expected_fracs[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  bit          hold_done;
  bit          hold_active;
  bit          send_pause;
  bit          in_fire;
  int unsigned mismatches;
  longint unsigned cycles;

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Euclid's loop with truncated remainder, seeded as gcd(numerator,
  // denominator). A divisor of -1 is special-cased so the most negative
  // value never overflows the hardware-independent arithmetic.
  function automatic reduced_t reduce_fraction(frac_op_t op);
    reduced_t res;
    longint a, b, c, d, n, dn, m, t, r, g, qn, qd;
    a = longint'(op.num_a);
    b = longint'(op.den_a);
    c = longint'(op.num_b);
    d = longint'(op.den_b);
    res = '0;
    case (op.kind)
      OpAdd, OpSub: begin
        if (b == 0 || d == 0) begin
          res.err = 1'b1;
          return res;
        end
        n  = (op.kind == OpAdd) ? a * d + c * b : a * d - c * b;
        dn = b * d;
      end
      OpMul: begin
        n  = a * c;
        dn = b * d;
      end
      default: begin
        n  = a * d;
        dn = b * c;
      end
    endcase
    m = n;
    t = dn;
    while (t != 0) begin
      r = (t == -1) ? 0 : m % t;
      m = t;
      t = r;
    end
    g = m;
    if (g == 0) begin
      res.err = 1'b1;
      return res;
    end
    qn = (g == -1) ? -n : n / g;
    qd = (g == -1) ? -dn : dn / g;
    res.num = qn[OutW-1:0];
    res.den = qd[OutW-1:0];
    return res;
  endfunction

  // Operand values lean toward zero, unity, the extremes and small numbers,
  // where the gcd loop and the error cases are most interesting.
  function automatic logic signed [Width-1:0] pick_operand();
    logic signed [Width-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = Width'(1);
      2:       v = '1;
      3:       v = {1'b1, {(Width-1){1'b0}}};
      4:       v = {1'b0, {(Width-1){1'b1}}};
      5, 6:    v = Width'($signed($urandom_range(0, 40)) - 20);
      7:       v = Width'($signed($urandom_range(0, 2000)) - 1000);
      default: v = Width'($urandom());
    endcase
    return v;
  endfunction

  function automatic frac_op_t random_op();
    frac_op_t op;
    op.kind  = op_e'($urandom_range(0, 3));
    op.num_a = pick_operand();
    op.den_a = pick_operand();
    op.num_b = pick_operand();
    op.den_b = pick_operand();
    return op;
  endfunction

  task automatic queue_op(op_e k, int na, int da, int nb, int db);
    frac_op_t op;
    op.kind  = k;
    op.num_a = na[Width-1:0];
    op.den_a = da[Width-1:0];
    op.num_b = nb[Width-1:0];
    op.den_b = db[Width-1:0];
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_fracs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Acceptance is sampled at the rising edge; the driver acts on it at the
  // following falling edge.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_if.valid && in_if.ready;
  end

  // Input driver: retires the accepted item, then decides whether to offer
  // the next one. An item still waiting keeps being offered unchanged.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid = 1'b0;
      in_if.kind  = '0;
      in_if.num_a = '0;
      in_if.den_a = '0;
      in_if.num_b = '0;
      in_if.den_b = '0;
    end else begin
      if (in_fire && pending_ops.size() != 0) begin
        expected_fracs.push_back(reduce_fraction(pending_ops.pop_front()));
      end
      if (pending_ops.size() != 0 &&
          ((in_if.valid && !in_fire) ||
           (!send_pause && $urandom_range(0, 99) >= send_idle_pct))) begin
        in_if.valid = 1'b1;
        in_if.kind  = pending_ops[0].kind;
        in_if.num_a = pending_ops[0].num_a;
        in_if.den_a = pending_ops[0].den_a;
        in_if.num_b = pending_ops[0].num_b;
        in_if.den_b = pending_ops[0].den_b;
      end else begin
        in_if.valid = 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles in its own process.
  always @(negedge clk_i) begin
    if (hold_request && !hold_done && !hold_active) begin
      hold_active = 1'b1;
      repeat (LongHold) @(negedge clk_i);
      hold_active = 1'b0;
      hold_done   = 1'b1;
    end
  end

  // Receiver ready, stalling at random per phase.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result monitor: every accepted result is compared with the oldest
  // expectation.
  always @(posedge clk_i) begin
    reduced_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_fracs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result num=%0d den=%0d err=%0b", out_if.result_num,
                   out_if.result_den, out_if.div_error);
        end
      end else begin
        exp_r = expected_fracs.pop_front();
        if (out_if.result_num !== exp_r.num || out_if.result_den !== exp_r.den ||
            out_if.div_error !== exp_r.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected num=%0d den=%0d err=%0b, got num=%0d den=%0d err=%0b",
                     $signed(exp_r.num), $signed(exp_r.den), exp_r.err,
                     out_if.result_num, out_if.result_den, out_if.div_error);
          end
        end
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    send_pause     = 1'b0;
    rst_ni         = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: each operation, zero denominators, zero over zero,
    // a zero denominator with a nonzero numerator, negative gcds and
    // the field extremes.
    queue_op(OpAdd, 1, 2, 1, 3);
    queue_op(OpSub, 1, 2, 1, 2);
    queue_op(OpMul, 2, 3, 3, 4);
    queue_op(OpDiv, 2, 3, 4, 9);
    queue_op(OpAdd, 1, 0, 1, 3);
    queue_op(OpSub, 1, 3, 1, 0);
    queue_op(OpAdd, 0, 0, 0, 0);
    queue_op(OpMul, 0, 5, 7, 0);
    queue_op(OpDiv, 0, 3, 0, 5);
    queue_op(OpMul, 3, 0, 5, 7);
    queue_op(OpDiv, 3, 4, 0, 7);
    queue_op(OpAdd, -1, 2, 1, -3);
    queue_op(OpMul, -6, 4, 9, -10);
    queue_op(OpAdd, -32768, -32768, -32768, -32768);
    queue_op(OpSub, 32767, -32768, -32768, 32767);
    queue_op(OpMul, -32768, 1, -32768, 1);
    queue_op(OpMul, -32768, -1, -32768, -1);
    queue_op(OpDiv, -32768, -1, -1, 32767);
    queue_op(OpDiv, 32767, 32767, 32767, 32767);
    queue_op(OpAdd, 32767, 32766, 32765, 32764);
    queue_op(OpSub, -1, -1, -1, -1);
    queue_op(OpMul, 0, 0, 0, 0);
    wait_drained();

    // Random phases: no idling, sender idling, receiver stalling, both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 19 : 0;
      for (int i = 0; i < 430; i++) pending_ops.push_back(random_op());
      if (phase == 0) begin
        // Receiver holds off while the sender keeps offering items.
        repeat (200) @(posedge clk_i);
        hold_request = 1'b1;
      end
      if (phase == 2) begin
        // Sender pauses until every outstanding result has been taken.
        repeat (2000) @(posedge clk_i);
        send_pause = 1'b1;
        while (expected_fracs.size() != 0 || in_if.valid) @(posedge clk_i);
        send_pause = 1'b0;
      end
      wait_drained();
    end

    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && expected_fracs.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### rational_arith_reduce.f
rtl/rar_pkg.sv
rtl/rar_if.sv
rtl/rar_div.sv
rtl/rational_arith_reduce.sv
verif/tb_top.sv
